>>> rtl/bsgs_pkg.sv
// Shared types and constants of the background subtraction unit.
// Used by bsgs_update and the top module; it depends on nothing else.
package bsgs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE     = 3'd4;

    localparam logic [1:0] MODE_NO_BLEND  = 2'd0;
    localparam logic [1:0] MODE_BLEND_ALL = 2'd1;
    localparam logic [1:0] MODE_BLEND_BKG = 2'd2;

    localparam logic [7:0] COUNT_MAX  = 8'd255;
    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    // Luma weights in Q14 and the rounding bias.
    localparam logic [21:0] GRAY_R_COEF = 22'd4899;
    localparam logic [21:0] GRAY_G_COEF = 22'd9617;
    localparam logic [21:0] GRAY_B_COEF = 22'd1868;
    localparam logic [21:0] GRAY_BIAS   = 22'd8192;

    typedef struct packed {
        logic [7:0] diff_threshold;
        logic [8:0] blend_weight;
        logic [1:0] update_mode;
        logic [7:0] ghost_limit;
        logic       color_mode;
    } bsgs_cfg_t;

    // Blue sits in the lowest byte, as in the background store.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bgr_t;

    typedef struct packed {
        logic [7:0] count;
        bgr_t       bkg;
    } bsgs_entry_t;

    typedef struct packed {
        logic        fg;
        bsgs_entry_t entry;
    } bsgs_upd_t;

endpackage

>>> rtl/bsgs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and a write of the same address return the old data.
module bsgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bsgs_update.sv
// Per-pixel decision and background update: foreground test, blend, run count
// and ghost overwrite. Depends on bsgs_pkg.
module bsgs_update (
    input  bsgs_pkg::bsgs_cfg_t   cfg,
    input  logic                  load,
    input  bsgs_pkg::bgr_t        pix,
    input  bsgs_pkg::bsgs_entry_t stored,
    output bsgs_pkg::bsgs_upd_t   upd
);
    import bsgs_pkg::*;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] blend8(input logic [7:0] p, input logic [7:0] b,
                                          input logic [8:0] w);
        logic [16:0] acc;
        acc = 17'(w) * 17'(p) + 17'(WEIGHT_ONE - w) * 17'(b) + 17'd128;
        return acc[15:8];
    endfunction

    logic [8:0]  weight;
    bgr_t        bkg;
    bgr_t        blended;
    logic        fg;
    logic        do_blend;
    logic [7:0]  count_inc;

    assign weight = (cfg.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.blend_weight;

    // In gray mode the upper channels of both pixel and background are zero,
    // so they never flag foreground and blend to zero.
    always_comb
    begin
        bkg.blue  = stored.bkg.blue;
        bkg.green = cfg.color_mode ? stored.bkg.green : 8'd0;
        bkg.red   = cfg.color_mode ? stored.bkg.red : 8'd0;
    end

    assign fg = (absdiff8(pix.blue, bkg.blue) > cfg.diff_threshold)
             || (absdiff8(pix.green, bkg.green) > cfg.diff_threshold)
             || (absdiff8(pix.red, bkg.red) > cfg.diff_threshold);

    assign blended.blue  = blend8(pix.blue, bkg.blue, weight);
    assign blended.green = blend8(pix.green, bkg.green, weight);
    assign blended.red   = blend8(pix.red, bkg.red, weight);

    assign do_blend  = (cfg.update_mode == MODE_BLEND_ALL)
                    || ((cfg.update_mode == MODE_BLEND_BKG) && !fg);
    assign count_inc = (stored.count < COUNT_MAX) ? stored.count + 8'd1 : stored.count;

    always_comb
    begin
        upd.fg          = 1'b0;
        upd.entry.count = 8'd0;
        upd.entry.bkg   = pix;
        if (!load)
        begin
            upd.fg        = fg;
            upd.entry.bkg = do_blend ? blended : bkg;
            if (fg)
            begin
                upd.entry.count = count_inc;
                if (count_inc > cfg.ghost_limit)
                begin
                    upd.entry.bkg = pix;
                end
            end
        end
    end

endmodule

>>> rtl/background_subtract_ghost_suppress_unit.sv
// Background subtraction with running-average update and ghost suppression.
// Input stream (s_axis): one pixel item per transfer; tuser is the load flag,
// tdata carries the pixel index and the blue, green and red channels.
// Output stream (m_axis): one result item per input item, in order; tuser is
// the foreground flag, tdata the index and the updated background channels.
// Config port (cfg_*): register index and data, always ready; write only when
// no item is in flight.
// Throughput is one item per clock while m_axis_tready is high. The accepting
// edge starts the synchronous read of the per-pixel store and moves the item
// into the update stage; the edge on which it leaves that stage registers the
// update, its write back and the result on m_axis. An item that hits
// the same pixel as the item just ahead of it takes the freshly written entry
// through a forwarding register instead of the stale read.
// Reset clears the control state and loads the register defaults; the pixel
// store is not cleared, so every pixel must be loaded before it is used.
// When m_axis_tready is low the result holds in the output register and one
// more item may sit in the update stage; after that s_axis_tready drops.
module background_subtract_ghost_suppress_unit #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata, // pixel_index, blue_in, green_in, red_in
    input  logic                           s_axis_tuser, // load_background
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata, // out_index, bkg_blue, bkg_green, bkg_red
    output logic                           m_axis_tuser, // foreground
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsgs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsgs_pkg::*;

    localparam int DEPTH = (FRAME_PIXELS > 65536) ? 65536 : FRAME_PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [22:0] FRAME_LIM = 23'(FRAME_PIXELS);

    bsgs_cfg_t   cfg_reg;

    logic        s1_valid_reg;
    logic        s1_load_reg;
    logic        s1_inrange_reg;
    logic [15:0] s1_index_reg;
    bgr_t        s1_pix_reg;
    logic        fwd_valid_reg;
    bsgs_entry_t fwd_entry_reg;

    logic        out_valid_reg;
    logic        out_fg_reg;
    logic [15:0] out_index_reg;
    bgr_t        out_bkg_reg;

    logic        in_accept;
    logic        s1_adv;
    logic [15:0] in_index;
    bgr_t        in_pix;
    bgr_t        in_pix_proc;
    logic [21:0] gray_sum;
    logic [31:0] ram_rdata;
    bsgs_entry_t stored;
    bsgs_upd_t   upd;
    logic        ram_we;
    logic        fwd_hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_threshold <= 8'd50;
            cfg_reg.blend_weight   <= 9'd13;
            cfg_reg.update_mode    <= MODE_BLEND_BKG;
            cfg_reg.ghost_limit    <= 8'd50;
            cfg_reg.color_mode     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DIFF_THRESHOLD: cfg_reg.diff_threshold <= cfg_data[7:0];
                CFG_BLEND_WEIGHT:   cfg_reg.blend_weight   <= cfg_data;
                CFG_UPDATE_MODE:    cfg_reg.update_mode    <= cfg_data[1:0];
                CFG_GHOST_LIMIT:    cfg_reg.ghost_limit    <= cfg_data[7:0];
                CFG_COLOR_MODE:     cfg_reg.color_mode     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Handshake and stage advance.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_index     = s_axis_tdata[15:0];
    assign in_pix.blue  = s_axis_tdata[23:16];
    assign in_pix.green = s_axis_tdata[31:24];
    assign in_pix.red   = s_axis_tdata[39:32];

    assign gray_sum = 22'(in_pix.red) * GRAY_R_COEF + 22'(in_pix.green) * GRAY_G_COEF
                    + 22'(in_pix.blue) * GRAY_B_COEF + GRAY_BIAS;

    always_comb
    begin
        in_pix_proc = in_pix;
        if (!cfg_reg.color_mode)
        begin
            in_pix_proc.blue  = gray_sum[21:14];
            in_pix_proc.green = 8'd0;
            in_pix_proc.red   = 8'd0;
        end
    end

    // The write of the item leaving the update stage lands on the same edge
    // as the read of the next item, so a matching address takes it forward.
    assign ram_we  = s1_adv && s1_inrange_reg;
    assign fwd_hit = ram_we && (in_index[AW-1:0] == s1_index_reg[AW-1:0]);

    bsgs_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(s1_index_reg[AW-1:0]),
        .wr_data(upd.entry),
        .rd_en  (in_accept),
        .rd_addr(in_index[AW-1:0]),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg  <= 1'b1;
            fwd_valid_reg <= fwd_hit;
        end
        else if (s1_adv)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_load_reg    <= s_axis_tuser;
            s1_inrange_reg <= ({7'd0, in_index} < FRAME_LIM);
            s1_index_reg   <= in_index;
            s1_pix_reg     <= in_pix_proc;
            fwd_entry_reg  <= upd.entry;
        end
    end

    assign stored = fwd_valid_reg ? fwd_entry_reg : ram_rdata;

    bsgs_update u_update (
        .cfg   (cfg_reg),
        .load  (s1_load_reg),
        .pix   (s1_pix_reg),
        .stored(stored),
        .upd   (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_index_reg <= s1_index_reg;
            out_fg_reg    <= s1_inrange_reg && upd.fg;
            out_bkg_reg   <= s1_inrange_reg ? upd.entry.bkg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_fg_reg;
    assign m_axis_tdata  = {out_bkg_reg.red, out_bkg_reg.green, out_bkg_reg.blue,
                            out_index_reg};

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forwarded entry without an item in the update stage");

    a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s1_valid_reg && (!out_valid_reg || m_axis_tready)))
        else $error("store written by an item that does not leave the stage");

    a_load_is_background: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_load_reg) |=> !m_axis_tuser)
        else $error("load item reported as foreground");

    a_out_of_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_inrange_reg) |=> (!m_axis_tuser && m_axis_tdata[39:16] == 24'd0))
        else $error("out-of-frame item produced nonzero result");

    a_gray_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !cfg_reg.color_mode) |=> (m_axis_tdata[39:24] == 16'd0))
        else $error("gray mode result has nonzero green or red");

endmodule

>>> sim/tb_background_subtract_ghost_suppress_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for background_subtract_ghost_suppress_unit.
// Drives pixel items and register writes, predicts every result in a scoreboard class.
// Depends on rtl/bsgs_pkg.sv and the unit's RTL.
module tb_background_subtract_ghost_suppress_unit;
    import bsgs_pkg::*;

    localparam int FRAME_PIXELS = 65536;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    class bgsub_scoreboard;
        typedef struct packed {
            logic        fg;
            logic [15:0] index;
            logic [7:0]  blue;
            logic [7:0]  green;
            logic [7:0]  red;
        } pixel_result_t;

        bsgs_cfg_t     cfg;
        bit [23:0]     bkg_word [0:65535];
        bit [7:0]      run_count [0:65535];
        pixel_result_t expected_pixels [$];
        int            mismatches;

        function new();
            cfg.diff_threshold = 8'd50;
            cfg.blend_weight   = 9'd13;
            cfg.update_mode    = MODE_BLEND_BKG;
            cfg.ghost_limit    = 8'd50;
            cfg.color_mode     = 1'b0;
            mismatches         = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIFF_THRESHOLD: cfg.diff_threshold = data[7:0];
                CFG_BLEND_WEIGHT:   cfg.blend_weight   = data[8:0];
                CFG_UPDATE_MODE:    cfg.update_mode    = data[1:0];
                CFG_GHOST_LIMIT:    cfg.ghost_limit    = data[7:0];
                CFG_COLOR_MODE:     cfg.color_mode     = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned blend(int unsigned p, int unsigned b, int unsigned w);
            return (w * p + (256 - w) * b + 128) >> 8;
        endfunction

        function void note_pixel(bit load, bit [15:0] idx, bit [7:0] b, bit [7:0] g,
                                 bit [7:0] r);
            pixel_result_t res;
            int unsigned   pix [3];
            int unsigned   bkg [3];
            int unsigned   w;
            int unsigned   y;
            int unsigned   cnt;
            int unsigned   diff;
            int            nch;
            bit            fg;
            bit [23:0]     word;

            res = '0;
            res.index = idx;
            fg = 1'b0;
            if (int'(idx) >= FRAME_PIXELS) begin
                expected_pixels.push_back(res);
                return;
            end
            w   = (cfg.blend_weight > WEIGHT_ONE) ? 256 : cfg.blend_weight;
            nch = cfg.color_mode ? 3 : 1;
            pix[0] = b;
            pix[1] = g;
            pix[2] = r;
            if (!cfg.color_mode) begin
                y = (r * 4899 + g * 9617 + b * 1868 + 8192) >> 14;
                pix[0] = y;
                pix[1] = 0;
                pix[2] = 0;
            end
            // A stored entry is read under the color mode that is active now.
            word   = bkg_word[idx];
            bkg[0] = word[7:0];
            bkg[1] = cfg.color_mode ? word[15:8] : 0;
            bkg[2] = cfg.color_mode ? word[23:16] : 0;

            if (load) begin
                for (int c = 0; c < 3; c++)
                    bkg[c] = pix[c];
                run_count[idx] = 8'd0;
            end else begin
                cnt = run_count[idx];
                for (int c = 0; c < nch; c++) begin
                    diff = (pix[c] > bkg[c]) ? pix[c] - bkg[c] : bkg[c] - pix[c];
                    if (diff > cfg.diff_threshold)
                        fg = 1'b1;
                end
                if (cfg.update_mode == MODE_BLEND_ALL ||
                    (cfg.update_mode == MODE_BLEND_BKG && !fg))
                    for (int c = 0; c < nch; c++)
                        bkg[c] = blend(pix[c], bkg[c], w);
                if (fg) begin
                    if (cnt < COUNT_MAX)
                        cnt++;
                    // A long foreground run means the background is a ghost.
                    if (cnt > cfg.ghost_limit)
                        for (int c = 0; c < nch; c++)
                            bkg[c] = pix[c];
                end else begin
                    cnt = 0;
                end
                run_count[idx] = cnt[7:0];
            end
            bkg_word[idx] = {bkg[2][7:0], bkg[1][7:0], bkg[0][7:0]};
            res.fg    = fg;
            res.blue  = bkg[0][7:0];
            res.green = bkg[1][7:0];
            res.red   = bkg[2][7:0];
            expected_pixels.push_back(res);
        endfunction

        function void check_pixel(logic fg, logic [39:0] data);
            pixel_result_t got;
            pixel_result_t want;

            got.fg    = fg;
            got.index = data[15:0];
            got.blue  = data[23:16];
            got.green = data[31:24];
            got.red   = data[39:32];
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: fg %b index %h bgr %h %h %h",
                             got.fg, got.index, got.blue, got.green, got.red);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.fg !== want.fg || got.index !== want.index || got.blue !== want.blue ||
                got.green !== want.green || got.red !== want.red) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected fg %b index %h bgr %h %h %h, ",
                              "got fg %b index %h bgr %h %h %h"},
                             want.fg, want.index, want.blue, want.green, want.red,
                             got.fg, got.index, got.blue, got.green, got.red);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bgsub_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    logic            hold_active = 1'b0;
    event            begin_long_stall;
    bit [15:0]       pool_index [16];

    background_subtract_ghost_suppress_unit #(
        .FRAME_PIXELS(FRAME_PIXELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: check each accepted item, then pick the next ready value.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tuser, m_axis_tdata);
        if (hold_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long receiver hold-off so the unit fills up and stalls its input.
    always
    begin
        @(begin_long_stall);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (60) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("background_subtract_ghost_suppress_unit regression: fail");
        $finish;
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input bit load, input bit [15:0] idx, input bit [7:0] b,
                              input bit [7:0] g, input bit [7:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= load;
        s_axis_tdata  <= {r, g, b, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pixel(load, idx, b, g, r);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic bit [7:0] near_value(bit [7:0] v);
        int d;
        int t;
        d = $urandom_range(0, 40);
        t = v + d - 20;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t[7:0];
    endfunction

    function automatic bit [7:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_setup(input bit color);
        bit [8:0] v;
        v = {1'($urandom_range(0, 1)), 8'($urandom_range(0, 60))};
        write_register(CFG_DIFF_THRESHOLD, v);
        v = 9'($urandom_range(0, 511));
        write_register(CFG_BLEND_WEIGHT, v);
        v = 9'($urandom_range(0, 3));
        write_register(CFG_UPDATE_MODE, v);
        v = 9'($urandom_range(0, 6));
        write_register(CFG_GHOST_LIMIT, v);
        write_register(CFG_COLOR_MODE, {8'd0, color});
    endtask

    // Mostly updates to a small set of pixels, close to their background so
    // both outcomes and long foreground runs occur; some loads, some far off.
    task automatic send_random_pixel();
        int        choice;
        bit [15:0] idx;
        bit [23:0] word;
        bit [7:0]  b;
        bit [7:0]  g;
        bit [7:0]  r;

        choice = $urandom_range(0, 99);
        idx = pool_index[$urandom_range(0, 15)];
        b = random_channel();
        g = random_channel();
        r = random_channel();
        if (choice < 6) begin
            idx = 16'($urandom_range(0, 65535));
            send_pixel(1'b1, idx, b, g, r);
        end else if (choice < 12) begin
            send_pixel(1'b1, idx, b, g, r);
        end else begin
            word = sb.bkg_word[idx];
            if ($urandom_range(0, 1)) begin
                if (sb.cfg.color_mode) begin
                    b = near_value(word[7:0]);
                    g = near_value(word[15:8]);
                    r = near_value(word[23:16]);
                end else begin
                    b = near_value(word[7:0]);
                    g = near_value(word[7:0]);
                    r = near_value(word[7:0]);
                end
            end
            send_pixel(1'b0, idx, b, g, r);
        end
    endtask

    initial
    begin
        bit [7:0] v;

        pool_index[0] = 16'h0000;
        pool_index[1] = 16'hFFFF;
        pool_index[2] = 16'h5555;
        pool_index[3] = 16'hAAAA;
        for (int i = 4; i < 16; i++)
            pool_index[i] = 16'($urandom_range(0, 65535));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset defaults: gray processing.
        send_pixel(1'b1, 16'h0000, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b1, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b1, 16'h5555, 8'd255, 8'd0, 8'd0);
        send_pixel(1'b1, 16'hAAAA, 8'd0, 8'd255, 8'd0);
        send_pixel(1'b0, 16'h0000, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 16'h0000, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 16'h5555, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 16'hAAAA, 8'd0, 8'd0, 8'd255);
        drain_results();

        // Color mode reading gray entries, unused update mode, weight above one.
        write_register(CFG_COLOR_MODE, 9'd1);
        write_register(CFG_DIFF_THRESHOLD, 9'd255);
        write_register(CFG_UPDATE_MODE, 9'd3);
        write_register(CFG_BLEND_WEIGHT, 9'd511);
        write_register(CFG_GHOST_LIMIT, 9'd255);
        write_register(CFG_UNUSED_INDEX, 9'h1FF);
        send_pixel(1'b0, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b1, 16'h5555, 8'd1, 8'd128, 8'd254);
        send_pixel(1'b0, 16'h5555, 8'd0, 8'd0, 8'd0);
        drain_results();

        write_register(CFG_DIFF_THRESHOLD, 9'd0);
        write_register(CFG_UPDATE_MODE, {7'd0, MODE_BLEND_ALL});
        write_register(CFG_BLEND_WEIGHT, 9'd0);
        write_register(CFG_GHOST_LIMIT, 9'd0);
        send_pixel(1'b0, 16'h5555, 8'd1, 8'd128, 8'd254);
        send_pixel(1'b0, 16'h5555, 8'd2, 8'd128, 8'd254);
        send_pixel(1'b0, 16'h0000, 8'd17, 8'd99, 8'd200);
        drain_results();

        write_register(CFG_BLEND_WEIGHT, WEIGHT_ONE);
        write_register(CFG_DIFF_THRESHOLD, 9'd128);
        send_pixel(1'b0, 16'hAAAA, 8'd40, 8'd200, 8'd90);
        drain_results();
        write_register(CFG_UPDATE_MODE, {7'd0, MODE_NO_BLEND});
        send_pixel(1'b0, 16'hFFFF, 8'd12, 8'd250, 8'd3);
        drain_results();

        // Random part, one idling pattern per phase.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            random_setup(phase[0]);
            if (phase == 0)
                for (int i = 0; i < 16; i++)
                    send_pixel(1'b1, pool_index[i], random_channel(), random_channel(),
                               random_channel());
            for (int i = 0; i < 50; i++) begin
                if (phase == 0 && i == 20)
                    -> begin_long_stall;
                // Pause the input until the unit has emptied.
                if (i == 25)
                    drain_results();
                send_random_pixel();
            end
            drain_results();
        end

        // Saturate one pixel's run counter, then let it overwrite the ghost.
        write_register(CFG_COLOR_MODE, 9'd0);
        write_register(CFG_UPDATE_MODE, {7'd0, MODE_NO_BLEND});
        write_register(CFG_DIFF_THRESHOLD, 9'd10);
        write_register(CFG_GHOST_LIMIT, 9'd255);
        send_pixel(1'b1, pool_index[0], 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 258; i++) begin
            v = i[0] ? 8'd200 : 8'd255;
            send_pixel(1'b0, pool_index[0], v, v, v);
        end
        drain_results();
        write_register(CFG_GHOST_LIMIT, 9'd254);
        send_pixel(1'b0, pool_index[0], 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, pool_index[0], 8'd255, 8'd255, 8'd255);
        drain_results();

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("background_subtract_ghost_suppress_unit regression: pass");
        else
            $display("background_subtract_ghost_suppress_unit regression: fail");
        $finish;
    end
endmodule
